// ===== design/tod_pkg.sv =====
`default_nettype none

package tod_pkg;

	// one input word: three outer atoms and the centre atom, signed Q8.24
	typedef struct packed {
		logic signed [31:0] outer1_x;
		logic signed [31:0] outer1_y;
		logic signed [31:0] outer1_z;
		logic signed [31:0] outer2_x;
		logic signed [31:0] outer2_y;
		logic signed [31:0] outer2_z;
		logic signed [31:0] outer3_x;
		logic signed [31:0] outer3_y;
		logic signed [31:0] outer3_z;
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic signed [31:0] centre_z;
	} in_word_t;

	// one result word: determinant in signed Q2.30 and zero-bond flag
	typedef struct packed {
		logic signed [31:0] orientation;
		logic               degenerate;
	} out_word_t;

	// bond vector component, exact difference of two Q8.24 values
	typedef logic signed [32:0] bond_diff_t;
	// unit vector component, signed Q2.30
	typedef logic signed [31:0] unit_t;

	localparam int NUM_BONDS  = 3;
	localparam int NUM_COMP   = 9;
	localparam int MAG_W      = 31;
	localparam int ROOT_W     = 32;
	localparam int QUO_W      = 31;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;
	localparam int NORM_MSB   = 30;
	localparam int FRAC_BITS  = 30;

endpackage

`default_nettype wire

// ===== design/tod_unit_pipe.sv =====
`default_nettype none

// Turns three bond vectors into unit vectors: normalize, sum of squares,
// bit-per-stage square root, bit-per-stage rounded division.
module tod_unit_pipe (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire tod_pkg::bond_diff_t diff [tod_pkg::NUM_COMP],
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      tod_pkg::unit_t    unit [tod_pkg::NUM_COMP],
	output      logic              degenerate
);
	import tod_pkg::*;

	localparam int ST_SQRT0 = 5;
	localparam int ST_DIVI  = ST_SQRT0 + SQRT_STEPS + 1;
	localparam int ST_DIV0  = ST_DIVI + 1;
	localparam int ST_OUT   = ST_DIV0 + DIV_STEPS;
	localparam int NS       = ST_OUT;

	typedef struct packed {
		logic [NUM_COMP-1:0][MAG_W-1:0] mag;
		logic [NUM_COMP-1:0]            sgn;
		logic [NUM_BONDS-1:0]           zero;
	} rt_side_t;

	typedef struct packed {
		logic [NUM_COMP-1:0]  sgn;
		logic [NUM_BONDS-1:0] zero;
	} dv_side_t;

	// highest set bit of a 33-bit magnitude
	function automatic logic [5:0] msb_pos(input logic [32:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 33; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	// valid bits and per-stage advance, bubbles collapse
	logic vld_q [1:NS];
	logic adv [1:NS+1];

	assign adv[NS+1] = out_ready;
	assign in_ready  = adv[1];
	assign out_valid = vld_q[NS];

	for (genvar k = 1; k <= NS; k++) begin : g_vld
		logic src;
		if (k == 1) begin : g_first
			assign src = in_valid;
		end else begin : g_next
			assign src = vld_q[k-1];
		end
		assign adv[k] = !vld_q[k] || adv[k+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_q[k] <= src;
			end
		end
	end

	// stage 1: magnitudes and signs
	logic [32:0] mag_s1 [NUM_COMP];
	logic        sgn_s1 [NUM_COMP];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				sgn_s1[i] <= diff[i][32];
				mag_s1[i] <= diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
			end
		end
	end

	// stage 2: leading one of the largest component
	logic [32:0] mag_s2 [NUM_COMP];
	logic        sgn_s2 [NUM_COMP];
	logic [5:0]  msb_s2 [NUM_BONDS];
	logic        zero_s2 [NUM_BONDS];
	logic [32:0] ormag [NUM_BONDS];

	always_comb begin
		for (int b = 0; b < NUM_BONDS; b++) begin
			ormag[b] = mag_s1[3*b] | mag_s1[3*b+1] | mag_s1[3*b+2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			mag_s2 <= mag_s1;
			sgn_s2 <= sgn_s1;
			for (int b = 0; b < NUM_BONDS; b++) begin
				msb_s2[b]  <= msb_pos(ormag[b]);
				zero_s2[b] <= (ormag[b] == '0);
			end
		end
	end

	// stage 3: common shift so the largest lands in [2^30, 2^31)
	logic [MAG_W-1:0] nrm_s3 [NUM_COMP];
	logic             sgn_s3 [NUM_COMP];
	logic             zero_s3 [NUM_BONDS];
	logic [32:0]      shf [NUM_COMP];

	always_comb begin
		for (int i = 0; i < NUM_COMP; i++) begin
			if (msb_s2[i/3] > 6'(NORM_MSB)) begin
				shf[i] = mag_s2[i] >> (msb_s2[i/3] - 6'(NORM_MSB));
			end else begin
				shf[i] = mag_s2[i] << (6'(NORM_MSB) - msb_s2[i/3]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				nrm_s3[i] <= shf[i][MAG_W-1:0];
			end
			sgn_s3  <= sgn_s2;
			zero_s3 <= zero_s2;
		end
	end

	// stage 4: squares
	logic [2*MAG_W-1:0] sqr_s4 [NUM_COMP];
	logic [MAG_W-1:0]   nrm_s4 [NUM_COMP];
	logic               sgn_s4 [NUM_COMP];
	logic               zero_s4 [NUM_BONDS];

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				sqr_s4[i] <= (2*MAG_W)'(nrm_s3[i]) * (2*MAG_W)'(nrm_s3[i]);
			end
			nrm_s4  <= nrm_s3;
			sgn_s4  <= sgn_s3;
			zero_s4 <= zero_s3;
		end
	end

	// square root pipeline; entry 0 is the sum-of-squares stage
	logic [63:0]       rt_rem_s  [0:SQRT_STEPS][NUM_BONDS];
	logic [ROOT_W-1:0] rt_root_s [0:SQRT_STEPS][NUM_BONDS];
	rt_side_t          rt_side_s [0:SQRT_STEPS];

	always_ff @(posedge clk) begin
		if (adv[ST_SQRT0]) begin
			for (int b = 0; b < NUM_BONDS; b++) begin
				rt_rem_s[0][b] <= 64'(sqr_s4[3*b]) + 64'(sqr_s4[3*b+1])
					+ 64'(sqr_s4[3*b+2]);
				rt_root_s[0][b] <= '0;
				rt_side_s[0].zero[b] <= zero_s4[b];
			end
			for (int i = 0; i < NUM_COMP; i++) begin
				rt_side_s[0].mag[i] <= nrm_s4[i];
				rt_side_s[0].sgn[i] <= sgn_s4[i];
			end
		end
	end

	// one root bit per stage, most significant first
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_rt
		localparam int J = SQRT_STEPS - 1 - k;
		logic [63:0] trial [NUM_BONDS];
		logic        take  [NUM_BONDS];

		always_comb begin
			for (int b = 0; b < NUM_BONDS; b++) begin
				trial[b] = (64'(rt_root_s[k][b]) << (J + 1)) | (64'd1 << (2 * J));
				take[b]  = rt_rem_s[k][b] >= trial[b];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[ST_SQRT0+k+1]) begin
				for (int b = 0; b < NUM_BONDS; b++) begin
					rt_rem_s[k+1][b]  <= take[b] ? rt_rem_s[k][b] - trial[b]
						: rt_rem_s[k][b];
					rt_root_s[k+1][b] <= take[b] ? rt_root_s[k][b] | (ROOT_W'(1) << J)
						: rt_root_s[k][b];
				end
				rt_side_s[k+1] <= rt_side_s[k];
			end
		end
	end

	// division pipeline; entry 0 forms a*2^30 + floor(L/2)
	logic [61:0]       dv_rem_s  [0:DIV_STEPS][NUM_COMP];
	logic [QUO_W-1:0]  dv_quo_s  [0:DIV_STEPS][NUM_COMP];
	logic [ROOT_W-1:0] dv_len_s  [0:DIV_STEPS][NUM_BONDS];
	dv_side_t          dv_side_s [0:DIV_STEPS];

	always_ff @(posedge clk) begin
		if (adv[ST_DIVI]) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				dv_rem_s[0][i] <= ({rt_side_s[SQRT_STEPS].mag[i], 31'b0} >> 1)
					+ 62'(rt_root_s[SQRT_STEPS][i/3] >> 1);
				dv_quo_s[0][i] <= '0;
			end
			for (int b = 0; b < NUM_BONDS; b++) begin
				dv_len_s[0][b] <= rt_root_s[SQRT_STEPS][b];
			end
			dv_side_s[0].sgn  <= rt_side_s[SQRT_STEPS].sgn;
			dv_side_s[0].zero <= rt_side_s[SQRT_STEPS].zero;
		end
	end

	// one quotient bit per stage, restoring
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
		localparam int J = DIV_STEPS - 1 - k;
		logic [61:0] dvs  [NUM_COMP];
		logic        take [NUM_COMP];

		always_comb begin
			for (int i = 0; i < NUM_COMP; i++) begin
				dvs[i]  = 62'(dv_len_s[k][i/3]) << J;
				take[i] = dv_rem_s[k][i] >= dvs[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[ST_DIV0+k]) begin
				for (int i = 0; i < NUM_COMP; i++) begin
					dv_rem_s[k+1][i] <= take[i] ? dv_rem_s[k][i] - dvs[i]
						: dv_rem_s[k][i];
					dv_quo_s[k+1][i] <= take[i] ? dv_quo_s[k][i] | (QUO_W'(1) << J)
						: dv_quo_s[k][i];
				end
				dv_len_s[k+1]  <= dv_len_s[k];
				dv_side_s[k+1] <= dv_side_s[k];
			end
		end
	end

	// last stage: restore signs
	unit_t unit_s70 [NUM_COMP];
	logic  dgn_s70;

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				unit_s70[i] <= dv_side_s[DIV_STEPS].sgn[i]
					? -$signed({1'b0, dv_quo_s[DIV_STEPS][i]})
					: $signed({1'b0, dv_quo_s[DIV_STEPS][i]});
			end
			dgn_s70 <= |dv_side_s[DIV_STEPS].zero;
		end
	end

	assign unit       = unit_s70;
	assign degenerate = dgn_s70;

endmodule

`default_nettype wire

// ===== design/tetrad_orientation_determinant.sv =====
// Orientation of a four-atom group: takes one word of twelve Q8.24
// coordinates per cycle and returns one word per input: the determinant of
// the three unit bond vectors (centre to each outer atom) in signed Q2.30,
// saturated to [-1.0, 1.0], and a degenerate flag that is set, with the
// determinant forced to 0, when any bond vector is zero. The block is a
// pipeline of 75 register stages that accepts a word every cycle while the
// result side does not stall; most of those stages are the 32-stage square
// root and the 31-stage divider that scale each bond to unit length. Stalls
// on the result side fill empty stages before they reach the input.
`default_nettype none

module tetrad_orientation_determinant (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output      logic              item_stall,
	input  wire tod_pkg::in_word_t item,
	output      logic              res_valid,
	input  wire logic              res_stall,
	output      tod_pkg::out_word_t res
);
	import tod_pkg::*;

	localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] Q30_ONE  = 64'sd1 <<< FRAC_BITS;

	// handshake chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic up_ready, up_valid;

	assign rdy5       = !vld_s5 || !res_stall;
	assign rdy4       = !vld_s4 || rdy5;
	assign rdy3       = !vld_s3 || rdy4;
	assign rdy2       = !vld_s2 || rdy3;
	assign rdy1       = !vld_s1 || up_ready;
	assign item_stall = !rdy1;
	assign res_valid  = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= item_valid;
			if (rdy2) vld_s2 <= up_valid;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: exact bond vectors, outer minus centre
	logic signed [31:0] outer [NUM_COMP];
	logic signed [31:0] ctr   [NUM_BONDS];
	bond_diff_t         diff_s1 [NUM_COMP];

	always_comb begin
		outer[0] = item.outer1_x;
		outer[1] = item.outer1_y;
		outer[2] = item.outer1_z;
		outer[3] = item.outer2_x;
		outer[4] = item.outer2_y;
		outer[5] = item.outer2_z;
		outer[6] = item.outer3_x;
		outer[7] = item.outer3_y;
		outer[8] = item.outer3_z;
		ctr[0]   = item.centre_x;
		ctr[1]   = item.centre_y;
		ctr[2]   = item.centre_z;
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				diff_s1[i] <= 33'(outer[i]) - 33'(ctr[i%3]);
			end
		end
	end

	// unit vectors
	unit_t unit_v [NUM_COMP];
	logic  up_dgn;

	tod_unit_pipe u_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (vld_s1),
		.in_ready   (up_ready),
		.diff       (diff_s1),
		.out_valid  (up_valid),
		.out_ready  (rdy2),
		.unit       (unit_v),
		.degenerate (up_dgn)
	);

	// stage 2: cross product partial products of u2 and u3
	logic signed [63:0] xp_s2 [6];
	unit_t              u1_s2 [NUM_BONDS];
	logic               dgn_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			xp_s2[0] <= 64'(unit_v[4]) * 64'(unit_v[8]);
			xp_s2[1] <= 64'(unit_v[5]) * 64'(unit_v[7]);
			xp_s2[2] <= 64'(unit_v[5]) * 64'(unit_v[6]);
			xp_s2[3] <= 64'(unit_v[3]) * 64'(unit_v[8]);
			xp_s2[4] <= 64'(unit_v[3]) * 64'(unit_v[7]);
			xp_s2[5] <= 64'(unit_v[4]) * 64'(unit_v[6]);
			for (int k = 0; k < NUM_BONDS; k++) begin
				u1_s2[k] <= unit_v[k];
			end
			dgn_s2 <= up_dgn;
		end
	end

	// stage 3: cross product components, rounded half up to Q2.30
	logic signed [63:0] xd   [NUM_BONDS];
	logic signed [63:0] xr   [NUM_BONDS];
	logic signed [32:0] cr_s3 [NUM_BONDS];
	unit_t              u1_s3 [NUM_BONDS];
	logic               dgn_s3;

	always_comb begin
		for (int k = 0; k < NUM_BONDS; k++) begin
			xd[k] = xp_s2[2*k] - xp_s2[2*k+1];
			xr[k] = (xd[k] + HALF_LSB) >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			for (int k = 0; k < NUM_BONDS; k++) begin
				cr_s3[k] <= xr[k][32:0];
			end
			u1_s3  <= u1_s2;
			dgn_s3 <= dgn_s2;
		end
	end

	// stage 4: dot product terms
	logic signed [63:0] dp_s4 [NUM_BONDS];
	logic               dgn_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			for (int k = 0; k < NUM_BONDS; k++) begin
				dp_s4[k] <= 64'(u1_s3[k]) * 64'(cr_s3[k]);
			end
			dgn_s4 <= dgn_s3;
		end
	end

	// stage 5: sum, round, saturate, output word
	logic signed [63:0] acc;
	logic signed [63:0] det;
	logic signed [31:0] det_sat;

	always_comb begin
		acc = dp_s4[0] + dp_s4[1] + dp_s4[2] + HALF_LSB;
		det = acc >>> FRAC_BITS;
		if (det > Q30_ONE) begin
			det_sat = Q30_ONE[31:0];
		end else if (det < -Q30_ONE) begin
			det_sat = 32'(-Q30_ONE);
		end else begin
			det_sat = det[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			res.orientation <= dgn_s4 ? '0 : det_sat;
			res.degenerate  <= dgn_s4;
		end
	end

endmodule

`default_nettype wire

// ===== design/tod_checker.sv =====
`default_nettype none

module tod_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_stall,
	input wire tod_pkg::in_word_t  item,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire tod_pkg::out_word_t res
);
	import tod_pkg::*;

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// a degenerate group always reports zero
	a_dgn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.degenerate |-> res.orientation == '0)
		else $error("degenerate word with nonzero orientation");

	// result never leaves [-1.0, 1.0]
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.orientation <= 32'sd1073741824)
			&& (res.orientation >= -32'sd1073741824))
		else $error("orientation out of range");

	// input side can only stall when the output side holds a word
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid || !res_stall |-> !item_stall)
		else $error("input stalled with output free");

endmodule

bind tetrad_orientation_determinant tod_checker u_tod_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
	import tod_pkg::*;

	localparam int LATENCY   = 75;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 750;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_word_t  item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_word_t res;

	tetrad_orientation_determinant DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected result words, oldest first
	out_word_t want_q[$];
	int        n_err = 0;
	int        idle_cycles = 0;
	bit        src_done = 1'b0;
	bit        hold_rx = 1'b0;

	task automatic report(input string what, input out_word_t got, input out_word_t exp);
		$display("tb: mismatch %s: got %0d/%0b want %0d/%0b", what,
			got.orientation, got.degenerate, exp.orientation, exp.degenerate);
		n_err++;
	endtask

	// integer square root, bit by bit
	function automatic longint unsigned root64(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Q4.60 to Q2.30, round half up
	function automatic longint round30(input longint v);
		return (v + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// scale one bond to unit length; returns 0 for a zero bond
	function automatic bit unit_bond(input longint d[3], output longint u[3]);
		longint unsigned a[3], mx, sum, len, q;
		mx = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
			if (a[i] > mx) mx = a[i];
		end
		if (mx == 0) return 1'b0;
		while (mx >= (64'd1 << 31)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) a[i] >>= 1;
		end
		while (mx < (64'd1 << 30)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) a[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) sum += a[i] * a[i];
		len = root64(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((a[i] << 30) + (len >> 1)) / len;
			u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic out_word_t orient_of(input in_word_t w);
		longint    p[12], d[3], u1[3], u2[3], u3[3], c[3], det;
		bit        ok;
		out_word_t r;
		p = '{w.outer1_x, w.outer1_y, w.outer1_z, w.outer2_x, w.outer2_y, w.outer2_z,
			w.outer3_x, w.outer3_y, w.outer3_z, w.centre_x, w.centre_y, w.centre_z};
		ok = 1'b1;
		for (int k = 0; k < 3; k++) d[k] = p[k] - p[9+k];
		if (!unit_bond(d, u1)) ok = 1'b0;
		for (int k = 0; k < 3; k++) d[k] = p[3+k] - p[9+k];
		if (!unit_bond(d, u2)) ok = 1'b0;
		for (int k = 0; k < 3; k++) d[k] = p[6+k] - p[9+k];
		if (!unit_bond(d, u3)) ok = 1'b0;
		r = '0;
		if (!ok) begin
			r.degenerate = 1'b1;
			return r;
		end
		c[0] = round30(u2[1] * u3[2] - u2[2] * u3[1]);
		c[1] = round30(u2[2] * u3[0] - u2[0] * u3[2]);
		c[2] = round30(u2[0] * u3[1] - u2[1] * u3[0]);
		det = round30(u1[0] * c[0] + u1[1] * c[1] + u1[2] * c[2]);
		if (det > (64'sd1 <<< 30)) det = 64'sd1 <<< 30;
		if (det < -(64'sd1 <<< 30)) det = -(64'sd1 <<< 30);
		r.orientation = det[31:0];
		return r;
	endfunction

	// directed table: word, expected, whether expected is typed in
	typedef struct {
		in_word_t  w;
		out_word_t exp;
		bit        fixed;
	} row_t;
	row_t table_rows[$];

	function automatic in_word_t mk(input int c[12]);
		in_word_t w;
		w = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
		return w;
	endfunction

	localparam int ONE = 32'sh0100_0000;
	localparam int MAXV = 32'sh7fff_ffff;
	localparam int MINV = 32'sh8000_0000;

	task automatic add_row(input int c[12], input bit fx, input int o, input bit dg);
		row_t r;
		r.w = mk(c);
		r.fixed = fx;
		r.exp.orientation = o;
		r.exp.degenerate = dg;
		table_rows.push_back(r);
	endtask

	function automatic in_word_t rand_word();
		in_word_t w;
		int       m;
		int       c[12];
		m = $urandom_range(0, 9);
		for (int i = 0; i < 12; i++) begin
			case (m)
				0: c[i] = $urandom();
				1: c[i] = $urandom_range(0, 3) - 1;
				2: c[i] = ($urandom_range(0, 1) ? MAXV : MINV) + $urandom_range(0, 2);
				default: c[i] = $signed($urandom()) >>> $urandom_range(0, 24);
			endcase
		end
		// occasionally collapse one bond onto the centre
		if ($urandom_range(0, 15) == 0) begin
			m = $urandom_range(0, 2);
			for (int k = 0; k < 3; k++) c[m*3+k] = c[9+k];
		end
		w = mk(c);
		return w;
	endfunction

	task automatic send(input in_word_t w);
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic gap();
		int n;
		n = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stimulus
	initial begin
		in_word_t w;
		out_word_t e;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// right-handed unit axes, left-handed, zero bonds, extremes
		add_row('{ONE,0,0, 0,ONE,0, 0,0,ONE, 0,0,0}, 1, 32'sh4000_0000, 0);
		add_row('{0,ONE,0, ONE,0,0, 0,0,ONE, 0,0,0}, 1, -32'sh4000_0000, 0);
		add_row('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1, 0, 1);
		add_row('{5,6,7, 1,2,3, 9,9,9, 5,6,7}, 1, 0, 1);
		add_row('{1,0,0, 0,1,0, 3,3,3, 3,3,3}, 1, 0, 1);
		add_row('{MAXV,0,0, 0,MAXV,0, 0,0,MAXV, MINV,MINV,MINV}, 0, 0, 0);
		add_row('{MINV,MAXV,MINV, MAXV,MINV,MAXV, MINV,MINV,MAXV, MAXV,MAXV,MINV}, 0, 0, 0);
		add_row('{MAXV,MAXV,MAXV, MINV,MINV,MINV, MAXV,MINV,MAXV, 0,0,0}, 0, 0, 0);
		add_row('{1,0,0, 0,1,0, 0,0,1, 0,0,0}, 1, 32'sh4000_0000, 0);
		add_row('{-1,-1,-1, 1,1,1, 1,-1,0, 0,0,0}, 0, 0, 0);
		add_row('{ONE,ONE,0, ONE,ONE,0, 0,0,ONE, 0,0,0}, 0, 0, 0);
		add_row('{-1,0,0, 0,-1,0, 0,0,-1, -1,-1,-1}, 0, 0, 0);
		add_row('{3,1,4, 1,5,9, 2,6,5, -3,-5,-8}, 0, 0, 0);
		foreach (table_rows[i]) begin
			e = table_rows[i].fixed ? table_rows[i].exp : orient_of(table_rows[i].w);
			want_q.push_back(e);
			send(table_rows[i].w);
			gap();
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// sender pause until drained
			if (n == 300) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (want_q.size() != 0) @(posedge clk);
			end
			// long receiver hold with back-to-back words
			if (n == 100) hold_rx = 1'b1;
			if (n == 260) hold_rx = 1'b0;
			w = rand_word();
			want_q.push_back(orient_of(w));
			send(w);
			if (!(n >= 100 && n < 260)) gap();
		end
		item_valid <= 1'b0;
		src_done = 1'b1;
	end

	// receiver stall pattern; a long hold is counted here in cycles
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				res_stall <= 1'b1;
				repeat (400) @(posedge clk);
				while (hold_rx) begin
					res_stall <= 1'b0;
					@(posedge clk);
				end
			end
			n = $urandom_range(0, 14);
			if ($urandom_range(0, 3) == 0) n = 0;
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (want_q.size() == 0) begin
				report("unexpected word", res, '0);
			end else begin
				if (res.orientation !== want_q[0].orientation)
					report("orientation", res, want_q[0]);
				if (res.degenerate !== want_q[0].degenerate)
					report("degenerate", res, want_q[0]);
				void'(want_q.pop_front());
			end
		end
		if ((item_valid && !item_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// end of run
	initial begin
		@(posedge arst_n);
		fork
			begin
				wait (src_done && want_q.size() == 0);
				repeat (LATENCY * 2) @(posedge clk);
				if (want_q.size() != 0) n_err++;
				if (n_err == 0)
					$display("tb: done, clean");
				else
					$display("tb: done, errors");
			end
			begin
				wait (idle_cycles >= WDOG_MAX);
				$display("tb: done, errors");
			end
		join_any
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/tod_pkg.sv
design/tod_unit_pipe.sv
design/tetrad_orientation_determinant.sv
design/tod_checker.sv
sim/tb.sv
